### hw/rtl/pcf_pkg.sv
package pcf_pkg;

  localparam int unsigned SymW    = 8;
  localparam int unsigned CodeW   = 5;
  localparam int unsigned Dim     = 5;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned RowW    = CodeW * Dim;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = RowW;

  localparam logic [SymW-1:0] SpaceSym  = 8'h20;
  localparam logic [SymW-1:0] PadSym    = 8'h7A;
  localparam logic [SymW-1:0] LetterLo  = 8'h61;
  localparam logic [SymW-1:0] LetterHi  = 8'h7A;
  localparam logic [SymW-1:0] UpperLo   = 8'h41;
  localparam logic [SymW-1:0] UpperHi   = 8'h5A;
  localparam logic [SymW-1:0] CaseShift = 8'h20;

  localparam logic [RowW-1:0] SquareRst [Dim] = '{
    25'd1739513, 25'd3735949, 25'd10788037, 25'd17979915, 25'd16208659
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode = 3'd0,
    CfgRow0 = 3'd1,
    CfgRow1 = 3'd2,
    CfgRow2 = 3'd3,
    CfgRow3 = 3'd4,
    CfgRow4 = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } loc_t;

endpackage

### hw/rtl/pcf_in_if.sv
interface pcf_in_if import pcf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            end_of_text;

  modport source (output valid, output symbol, output end_of_text, input ready);
  modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

### hw/rtl/pcf_out_if.sv
interface pcf_out_if import pcf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SymW-1:0] out_symbol;
  logic            pair_unmapped;
  logic            last;

  modport source (output valid, output out_symbol, output pair_unmapped, output last,
                  input ready);
  modport sink   (input valid, input out_symbol, input pair_unmapped, input last,
                  output ready);
endinterface

### hw/rtl/playfair_digraph_cipher.sv
// channel   direction  beat contents                          handshake
// in_ch     sink       symbol, end_of_text                    valid/ready
// out_ch    source     out_symbol, pair_unmapped, last        valid/ready
// cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i        enable only
//
// A byte that completes a pair is held in the pair register, then in the result
// register, and leaves as two beats. Ordinary text flows at one byte per cycle
// while the output accepts every beat; a byte that completes a pair on its own (an
// end mark on an unpaired symbol) gives two beats, so the serialiser paces those.
// Reset (async, active low) clears the held symbol, the stage valids and the mode,
// and loads the default key square. Input stalls only while a pair waits for the serialiser.
module playfair_digraph_cipher import pcf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  pcf_in_if.sink             in_ch,
  pcf_out_if.source          out_ch,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic            mode_q;
  logic [RowW-1:0] row_q [Dim];

  logic            holding_q, holding_d;
  logic [SymW-1:0] held_q, held_d;

  logic            pair_v_q, pair_v_d;
  logic [SymW-1:0] pair_a_q, pair_a_d, pair_b_q, pair_b_d;
  logic            pair_last_q, pair_last_d;
  logic            pair_new;

  logic            res_v_q, res_second_q, res_miss_q, res_last_q;
  logic [SymW-1:0] res_a_q, res_b_q, res_a_d, res_b_d;
  logic            res_miss_d;

  logic            in_fire, out_fire, res_free, res_load;
  logic [SymW-1:0] sym_n;
  logic            is_space;

  logic [CodeW-1:0] sq_cell [Dim][Dim];
  loc_t             loc_a, loc_b;
  logic [IdxW-1:0]  ra, ca, rb, cb;

  function automatic loc_t locate(input logic [SymW-1:0] s,
                                  input logic [CodeW-1:0] sq [Dim][Dim]);
    loc_t             l;
    logic [CodeW-1:0] code;
    l    = '0;
    code = CodeW'(s - LetterLo);
    if (s >= LetterLo && s <= LetterHi) begin
      for (int i = Dim - 1; i >= 0; i--) begin
        for (int j = Dim - 1; j >= 0; j--) begin
          if (sq[i][j] == code) begin
            l.found = 1'b1;
            l.row   = IdxW'(i);
            l.col   = IdxW'(j);
          end
        end
      end
    end
    return l;
  endfunction

  function automatic logic [IdxW-1:0] step5(input logic [IdxW-1:0] v, input logic dec);
    logic [IdxW-1:0] r;
    if (dec) begin
      r = (v == '0) ? IdxW'(Dim - 1) : v - IdxW'(1);
    end else begin
      r = (v == IdxW'(Dim - 1)) ? '0 : v + IdxW'(1);
    end
    return r;
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      for (int i = 0; i < Dim; i++) begin
        row_q[i] <= SquareRst[i];
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMode: mode_q   <= cfg_data_i[0];
        CfgRow0: row_q[0] <= cfg_data_i;
        CfgRow1: row_q[1] <= cfg_data_i;
        CfgRow2: row_q[2] <= cfg_data_i;
        CfgRow3: row_q[3] <= cfg_data_i;
        CfgRow4: row_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign res_free = !res_v_q || (out_fire && res_second_q);
  assign res_load = pair_v_q && res_free;
  assign in_ch.ready = !pair_v_q || res_load;

  assign is_space = (in_ch.symbol == SpaceSym);
  assign sym_n = (in_ch.symbol >= UpperLo && in_ch.symbol <= UpperHi) ?
                 in_ch.symbol + CaseShift : in_ch.symbol;

  // pairing
  always_comb begin
    holding_d   = holding_q;
    held_d      = held_q;
    pair_new    = 1'b0;
    pair_a_d    = pair_a_q;
    pair_b_d    = pair_b_q;
    pair_last_d = pair_last_q;
    if (in_fire) begin
      if (!is_space) begin
        if (holding_q) begin
          pair_new    = 1'b1;
          pair_a_d    = held_q;
          pair_b_d    = sym_n;
          pair_last_d = in_ch.end_of_text;
          holding_d   = 1'b0;
        end else begin
          held_d    = sym_n;
          holding_d = 1'b1;
        end
      end
      if (in_ch.end_of_text) begin
        if (holding_d) begin
          pair_new    = 1'b1;
          pair_a_d    = held_d;
          pair_b_d    = PadSym;
          pair_last_d = 1'b1;
        end
        holding_d = 1'b0;
        held_d    = '0;
      end
    end
    pair_v_d = pair_new ? 1'b1 : (res_load ? 1'b0 : pair_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holding_q <= 1'b0;
      held_q    <= '0;
      pair_v_q  <= 1'b0;
    end else begin
      holding_q <= holding_d;
      held_q    <= held_d;
      pair_v_q  <= pair_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_a_q    <= pair_a_d;
    pair_b_q    <= pair_b_d;
    pair_last_q <= pair_last_d;
  end

  // key square lookup
  always_comb begin
    for (int i = 0; i < Dim; i++) begin
      for (int j = 0; j < Dim; j++) begin
        sq_cell[i][j] = row_q[i][j*CodeW +: CodeW];
      end
    end
  end

  assign loc_a = locate(pair_a_q, sq_cell);
  assign loc_b = locate(pair_b_q, sq_cell);

  always_comb begin
    ra = loc_a.row;
    ca = loc_a.col;
    rb = loc_b.row;
    cb = loc_b.col;
    if (loc_a.row == loc_b.row) begin
      ca = step5(loc_a.col, mode_q);
      cb = step5(loc_b.col, mode_q);
    end else if (loc_a.col == loc_b.col) begin
      ra = step5(loc_a.row, mode_q);
      rb = step5(loc_b.row, mode_q);
    end else begin
      ca = loc_b.col;
      cb = loc_a.col;
    end
    if (loc_a.found && loc_b.found) begin
      res_a_d    = SymW'(sq_cell[ra][ca]) + LetterLo;
      res_b_d    = SymW'(sq_cell[rb][cb]) + LetterLo;
      res_miss_d = 1'b0;
    end else begin
      res_a_d    = pair_a_q;
      res_b_d    = pair_b_q;
      res_miss_d = 1'b1;
    end
  end

  // result register and two-beat serialiser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q      <= 1'b0;
      res_second_q <= 1'b0;
    end else if (res_load) begin
      res_v_q      <= 1'b1;
      res_second_q <= 1'b0;
    end else if (out_fire) begin
      if (res_second_q) begin
        res_v_q      <= 1'b0;
        res_second_q <= 1'b0;
      end else begin
        res_second_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_a_q    <= res_a_d;
      res_b_q    <= res_b_d;
      res_miss_q <= res_miss_d;
      res_last_q <= pair_last_q;
    end
  end

  assign out_ch.valid         = res_v_q;
  assign out_ch.out_symbol    = res_second_q ? res_b_q : res_a_q;
  assign out_ch.pair_unmapped = res_miss_q;
  assign out_ch.last          = res_second_q && res_last_q;

`ifndef ASSERT_OFF
  a_second_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_second_q |-> res_v_q) else $error("second beat without a result");

  a_first_then_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !res_second_q |=> res_v_q && res_second_q)
    else $error("pair lost its second beat");

  a_pair_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_v_q && !res_free |=> pair_v_q && $stable(pair_a_q) && $stable(pair_b_q))
    else $error("pending pair overwritten");

  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_ch.end_of_text |=> !holding_q)
    else $error("symbol held past end of text");
`endif

endmodule
